// ----- rtl/avz_pkg.sv -----
// ----------------------------------------------------------------------------
// avz_pkg
// shared width helpers for the vector to z axis rotation core
// ----------------------------------------------------------------------------
package avz_pkg;

  localparam int NUM_LANES = 8;

  // width of the residual and partial product words in a root cell
  function automatic int res_bits(input int coord_bits, input int frac_bits);
    return 4 * coord_bits + 2 * frac_bits + 6;
  endfunction

endpackage

// ----- rtl/avz_cell.sv -----
// ----------------------------------------------------------------------------
// avz_cell
// one digit of the rounded square root of a ratio, one register stage
// ----------------------------------------------------------------------------
module avz_cell
  import avz_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14,
  parameter int BIT        = 0
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic signed [res_bits(COORD_BITS, FRAC_BITS)-1:0] e_in,
  input  logic signed [res_bits(COORD_BITS, FRAC_BITS)-1:0] p_in,
  input  logic        [4*COORD_BITS-1:0]                d_in,
  input  logic        [FRAC_BITS:0]                     q_in,
  output logic signed [res_bits(COORD_BITS, FRAC_BITS)-1:0] e_out,
  output logic signed [res_bits(COORD_BITS, FRAC_BITS)-1:0] p_out,
  output logic        [4*COORD_BITS-1:0]                d_out,
  output logic        [FRAC_BITS:0]                     q_out
);

  localparam int EW = res_bits(COORD_BITS, FRAC_BITS);
  localparam int PW = 4 * COORD_BITS;

  logic signed [EW-1:0] d_ext;
  logic signed [EW-1:0] trial;
  logic signed [EW-1:0] diff;
  logic                 ok;
  logic        [FRAC_BITS:0] q_next;

  always_comb begin
    d_ext  = signed'({{(EW-PW){1'b0}}, d_in});
    trial  = (p_in <<< (BIT + 2)) + (d_ext <<< (2 * BIT + 2));
    diff   = e_in - trial;
    ok     = ~diff[EW-1];
    q_next = q_in;
    q_next[BIT] = ok;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_out <= ok ? diff : e_in;
      p_out <= ok ? (p_in + (d_ext <<< (BIT + 1))) : p_in;
      d_out <= d_in;
      q_out <= q_next;
    end
  end

endmodule

// ----- rtl/avz_lane.sv -----
// ----------------------------------------------------------------------------
// avz_lane
// chain of root cells giving round(sqrt(num/den) * 2^frac) for one entry
// ----------------------------------------------------------------------------
module avz_lane
  import avz_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [4*COORD_BITS-1:0] num,
  input  logic [4*COORD_BITS-1:0] den,
  output logic [FRAC_BITS:0]      q
);

  localparam int EW = res_bits(COORD_BITS, FRAC_BITS);
  localparam int PW = 4 * COORD_BITS;
  localparam int NC = FRAC_BITS + 1;

  logic signed [EW-1:0] e_c [NC+1];
  logic signed [EW-1:0] p_c [NC+1];
  logic        [PW-1:0] d_c [NC+1];
  logic [FRAC_BITS:0]   q_c [NC+1];

  logic signed [EW-1:0] num_ext;
  logic signed [EW-1:0] den_ext;

  // start from q = 0, i.e. t = 2q - 1 = -1
  assign num_ext = signed'({{(EW-PW){1'b0}}, num});
  assign den_ext = signed'({{(EW-PW){1'b0}}, den});
  assign e_c[0]  = (num_ext <<< (2 * FRAC_BITS + 2)) - den_ext;
  assign p_c[0]  = -den_ext;
  assign d_c[0]  = den;
  assign q_c[0]  = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    avz_cell #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .BIT       (FRAC_BITS - i)
    ) u_cell (
      .clk  (clk),
      .en   (en),
      .e_in (e_c[i]),
      .p_in (p_c[i]),
      .d_in (d_c[i]),
      .q_in (q_c[i]),
      .e_out(e_c[i+1]),
      .p_out(p_c[i+1]),
      .d_out(d_c[i+1]),
      .q_out(q_c[i+1])
    );
  end

  assign q = q_c[NC];

endmodule

// ----- rtl/align_vector_to_z_rotation_core.sv -----
// throughput: one vector per cycle while no output beat waits under stall, set by the pipelined root cell chains
// the whole pipeline holds while an output beat waits under stall
// reset clears only the valid bits of the pipeline, payload is not reset
// ----------------------------------------------------------------------------
// align_vector_to_z_rotation_core
// rotation matrix that turns a vector onto the z axis, Q1.FRAC_BITS entries
// ----------------------------------------------------------------------------
module align_vector_to_z_rotation_core
  import avz_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  vec_x,
  input  logic signed [COORD_BITS-1:0]  vec_y,
  input  logic signed [COORD_BITS-1:0]  vec_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [FRAC_BITS+1:0]   m00,
  output logic signed [FRAC_BITS+1:0]   m01,
  output logic signed [FRAC_BITS+1:0]   m02,
  output logic signed [FRAC_BITS+1:0]   m10,
  output logic signed [FRAC_BITS+1:0]   m11,
  output logic signed [FRAC_BITS+1:0]   m12,
  output logic signed [FRAC_BITS+1:0]   m20,
  output logic signed [FRAC_BITS+1:0]   m21,
  output logic signed [FRAC_BITS+1:0]   m22,
  output logic                          degenerate
);

  localparam int CB = COORD_BITS;
  localparam int SW = 2 * CB;
  localparam int PW = 4 * CB;
  localparam int OW = FRAC_BITS + 2;
  localparam int NC = FRAC_BITS + 1;
  localparam int NL = NUM_LANES;

  logic en;
  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  // stage 0: magnitudes
  logic          v0;
  logic [CB-1:0] mx, my, mz;
  logic          sx0, sy0, sz0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx0 <= vec_x[CB-1];
      sy0 <= vec_y[CB-1];
      sz0 <= vec_z[CB-1];
      mx  <= vec_x[CB-1] ? (~vec_x + 1'b1) : vec_x;
      my  <= vec_y[CB-1] ? (~vec_y + 1'b1) : vec_y;
      mz  <= vec_z[CB-1] ? (~vec_z + 1'b1) : vec_z;
    end
  end

  // stage 1: squares
  logic          v1;
  logic [SW-1:0] x2a, y2a, z2a;
  logic          sx1, sy1, sz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2a <= mx * mx;
      y2a <= my * my;
      z2a <= mz * mz;
      sx1 <= sx0;
      sy1 <= sy0;
      sz1 <= sz0;
    end
  end

  // stage 2: sums of squares
  logic          v2;
  logic [SW-1:0] x2b, y2b, z2b, aa, ss;
  logic          sx2, sy2, sz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2b <= x2a;
      y2b <= y2a;
      z2b <= z2a;
      aa  <= x2a + y2a;
      ss  <= x2a + y2a + z2a;
      sx2 <= sx1;
      sy2 <= sy1;
      sz2 <= sz1;
    end
  end

  // stage 3: numerator and denominator per entry
  logic          v3;
  logic [PW-1:0] num [NL];
  logic [PW-1:0] den [NL];
  logic [NL-1:0] neg3;
  logic          dg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= x2b * z2b;
      den[0] <= aa * ss;
      num[1] <= y2b * z2b;
      den[1] <= aa * ss;
      num[2] <= {{(PW-SW){1'b0}}, aa};
      den[2] <= {{(PW-SW){1'b0}}, ss};
      num[3] <= {{(PW-SW){1'b0}}, y2b};
      den[3] <= {{(PW-SW){1'b0}}, aa};
      num[4] <= {{(PW-SW){1'b0}}, x2b};
      den[4] <= {{(PW-SW){1'b0}}, aa};
      num[5] <= {{(PW-SW){1'b0}}, x2b};
      den[5] <= {{(PW-SW){1'b0}}, ss};
      num[6] <= {{(PW-SW){1'b0}}, y2b};
      den[6] <= {{(PW-SW){1'b0}}, ss};
      num[7] <= {{(PW-SW){1'b0}}, z2b};
      den[7] <= {{(PW-SW){1'b0}}, ss};
      neg3   <= {sz2, sy2, sx2, sx2, ~sy2, 1'b1, sy2 ^ sz2, sx2 ^ sz2};
      dg3    <= (aa == '0);
    end
  end

  // root cell chains
  logic [FRAC_BITS:0] q [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    avz_lane #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk(clk),
      .en (en),
      .num(num[l]),
      .den(den[l]),
      .q  (q[l])
    );
  end

  // side pipe for valid, signs and degenerate flag
  logic          vp   [NC];
  logic [NL-1:0] negp [NC];
  logic          dgp  [NC];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NC; i++) begin
        vp[i] <= 1'b0;
      end
    end else if (en) begin
      vp[0] <= v3;
      for (int i = 1; i < NC; i++) begin
        vp[i] <= vp[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      negp[0] <= neg3;
      dgp[0]  <= dg3;
      for (int i = 1; i < NC; i++) begin
        negp[i] <= negp[i-1];
        dgp[i]  <= dgp[i-1];
      end
    end
  end

  // output register
  logic [OW-1:0] ent [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      if (dgp[NC-1]) begin
        ent[l] = '0;
      end else if (negp[NC-1][l]) begin
        ent[l] = ~{1'b0, q[l]} + 1'b1;
      end else begin
        ent[l] = {1'b0, q[l]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vp[NC-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m00        <= ent[0];
      m01        <= ent[1];
      m02        <= ent[2];
      m10        <= ent[3];
      m11        <= ent[4];
      m12        <= '0;
      m20        <= ent[5];
      m21        <= ent[6];
      m22        <= ent[7];
      degenerate <= dgp[NC-1];
    end
  end

endmodule

// ----- tb/align_vector_to_z_rotation_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// align_vector_to_z_rotation_core_test
// drives vectors through the rotation core with random gaps and output stall,
// predicts every matrix entry by exact integer rounding and checks each beat
// ----------------------------------------------------------------------------
module align_vector_to_z_rotation_core_test;

  localparam int CB = 16;
  localparam int FB = 14;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [CB-1:0] x, y, z;
  } vec_t;

  typedef struct packed {
    logic signed [FB+1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic                 degenerate;
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [FB+1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic degenerate;

  vec_t    pending_vecs[$];
  matrix_t expected_mats[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      in_gap = 0;
  int      out_gap = 0;
  bit      in_taken = 0;

  align_vector_to_z_rotation_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22), .degenerate(degenerate)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // largest q in [0, 2^FB] with q - 1/2 <= sqrt(n1*n2/(d1*d2)) * 2^FB
  function automatic logic [FB:0] rounded_ratio(input logic [63:0] n1, n2, d1, d2);
    logic [127:0] rhs, lhs;
    logic [31:0] lo, hi, mid, t;
    rhs = (128'(n1) * 128'(n2)) << (2 * FB + 2);
    lo = 0;
    hi = 32'd1 << FB;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      lhs = 128'(d1) * 128'(d2) * 128'(t) * 128'(t);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[FB:0];
  endfunction

  function automatic logic signed [FB+1:0] signed_entry(input logic [FB:0] q, input bit neg);
    logic signed [FB+1:0] v;
    v = {1'b0, q};
    return neg ? -v : v;
  endfunction

  function automatic matrix_t rotation_of(input vec_t v);
    matrix_t r;
    logic [63:0] mx, my, mz, x2, y2, z2, aa, ss;
    bit sx, sy, sz;
    sx = v.x[CB-1]; sy = v.y[CB-1]; sz = v.z[CB-1];
    mx = sx ? 64'(-64'(signed'(v.x))) : 64'(v.x);
    my = sy ? 64'(-64'(signed'(v.y))) : 64'(v.y);
    mz = sz ? 64'(-64'(signed'(v.z))) : 64'(v.z);
    x2 = mx * mx; y2 = my * my; z2 = mz * mz;
    aa = x2 + y2;
    ss = aa + z2;
    r = '0;
    if (aa == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    r.m00 = signed_entry(rounded_ratio(x2, z2, aa, ss), sx != sz);
    r.m01 = signed_entry(rounded_ratio(y2, z2, aa, ss), sy != sz);
    r.m02 = signed_entry(rounded_ratio(aa, 1, ss, 1), 1'b1);
    r.m10 = signed_entry(rounded_ratio(y2, 1, aa, 1), !sy);
    r.m11 = signed_entry(rounded_ratio(x2, 1, aa, 1), sx);
    r.m20 = signed_entry(rounded_ratio(x2, 1, ss, 1), sx);
    r.m21 = signed_entry(rounded_ratio(y2, 1, ss, 1), sy);
    r.m22 = signed_entry(rounded_ratio(z2, 1, ss, 1), sz);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [CB-1:0] rand_coord(input int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($signed($urandom_range(0, 16)) - 8);
      default: return ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000) + CB'($urandom_range(0, 3));
    endcase
  endfunction

  // input beat accepted, predict
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    in_taken = 0;
    if (!rst && in_valid && !in_stall) begin
      expected_mats.push_back(rotation_of('{vec_x, vec_y, vec_z}));
      in_taken = 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    matrix_t got, exp_m;
    if (!rst && out_valid && !out_stall) begin
      got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate};
      if (expected_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h", got);
      end else begin
        exp_m = expected_mats.pop_front();
        if (got !== exp_m) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch expected %h actual %h", exp_m, got);
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    vec_t v;
    if (!rst && !(in_valid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_vecs.size() > 0) begin
        v = pending_vecs.pop_front();
        vec_x <= v.x; vec_y <= v.y; vec_z <= v.z;
        in_valid <= 1'b1;
        in_gap <= (cycles % 3000 < 500) ? 0 : pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (!rst) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= (cycles % 3000 < 500) ? 0 : pick_gap();
      end
    end
  end

  initial begin
    vec_t v;
    int mode;
    pending_vecs.push_back('{16'sd0, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sd0, 16'sd0, 16'sd5});
    pending_vecs.push_back('{16'sd0, 16'sd0, -16'sd32768});
    pending_vecs.push_back('{16'sd1, 16'sd0, 16'sd0});
    pending_vecs.push_back('{-16'sd32768, 16'sd0, 16'sd0});
    pending_vecs.push_back('{16'sd0, 16'sd32767, 16'sd0});
    pending_vecs.push_back('{16'sd0, -16'sd1, 16'sd0});
    pending_vecs.push_back('{-16'sd32768, -16'sd32768, -16'sd32768});
    pending_vecs.push_back('{16'sd32767, 16'sd32767, 16'sd32767});
    pending_vecs.push_back('{16'sd32767, -16'sd32768, 16'sd32767});
    pending_vecs.push_back('{16'sd3, 16'sd4, 16'sd0});
    pending_vecs.push_back('{-16'sd3, 16'sd4, 16'sd12});
    pending_vecs.push_back('{16'sd1, 16'sd2, -16'sd2});
    pending_vecs.push_back('{16'sd1, 16'sd1, 16'sd1});
    pending_vecs.push_back('{-16'sd1, -16'sd1, 16'sd0});
    pending_vecs.push_back('{16'sd1, 16'sd32767, -16'sd32768});
    pending_vecs.push_back('{16'sd0, 16'sd1, -16'sd1});
    pending_vecs.push_back('{16'sd2, 16'sd0, 16'sd2});
    for (int i = 0; i < 1200; i++) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 6) ? 0 : (mode < 9) ? 1 : 2;
      v.x = rand_coord(mode);
      v.y = rand_coord(mode);
      v.z = rand_coord($urandom_range(0, 2));
      if ($urandom_range(0, 29) == 0) begin
        v.x = '0;
        v.y = '0;
      end
      pending_vecs.push_back(v);
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending_vecs.size() != 0 || in_valid) @(posedge clk);
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (FB + 40) @(posedge clk);
    if (mismatches == 0 && expected_mats.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/avz_pkg.sv
rtl/avz_cell.sv
rtl/avz_lane.sv
rtl/align_vector_to_z_rotation_core.sv
tb/align_vector_to_z_rotation_core_test.sv
